// ===== src/cirf_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN id rule filter package
// Shared widths, defaults, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cirf_pkg;

  // Parameter defaults
  localparam int NumRulesDef = 16;
  localparam int IdBitsDef   = 29;

  // Field widths of the stream payloads
  localparam int IdFieldW = 29;
  localparam int ModeW    = 3;
  localparam int TypeW    = 2;
  localparam int IndexW   = 4;
  localparam int StatusW  = 2;
  localparam int SlotW    = 4;
  localparam int CountW   = 5;
  localparam int InDataW  = 104;
  localparam int OutDataW = 80;

  // Configuration register word indexes
  localparam logic RegFilterOn = 1'b0;

  typedef enum logic [ModeW-1:0] {
    MODE_CHECK  = 3'd0,
    MODE_ADD    = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_SET_EN = 3'd3,
    MODE_CLEAR  = 3'd4,
    MODE_READ   = 3'd5
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REMOVE,
    ST_SET_EN,
    ST_READ,
    ST_DONE
  } state_e;

  // Outcome of comparing one stored rule against a frame
  typedef struct packed {
    logic hit;        // enabled, type equal, masked id equal
    logic acc_rule;   // enabled accept rule
    logic decision;   // accept bit of the rule
  } eval_t;

endpackage

`default_nettype wire

// ===== src/can_id_rule_filter_core.sv =====
// ----------------------------------------------------------------------------
// CAN id rule filter core
// Ordered table of CAN identifier rules in a one-port-pair synchronous RAM,
// walked one rule per cycle for frame checks and for remove shifts.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: tuser carries the operation (check, add, remove,
//   set enable, clear, read), tdata the frame and rule fields. Every transfer
//   gives exactly one result transfer on m_axis_*.
//   APB port: register 0 (filter_on) at byte address 0. Write it only while
//   no item is in flight.
// Steps, from input transfer to result valid:
//   check           reads rules in order from rule zero to the first hit;
//                   no walk when filtering is off or the table is empty
//   remove          one RAM read/write per shifted rule
//   set enable/read one RAM read; set enable then modifies and writes back
//   add/clear/error no RAM read
//   One item is in work at a time; the next transfer is taken once the
//   result sits in the output register. The rule RAM read port sets the
//   pace: one rule per cycle.
// Reset: the rule count and filter_on clear; table contents are don't-care
//   since only entries below the count are ever read. No clearing pass.
// Stall: while m_axis_tready is low the result holds in the output register
//   and one further item may be taken and worked; it waits to finish.
// ----------------------------------------------------------------------------
`default_nettype none

module can_id_rule_filter_core #(
  parameter int NUM_RULES = cirf_pkg::NumRulesDef,
  parameter int ID_BITS   = cirf_pkg::IdBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input item stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low bit up: msg_id(29) msg_type(2) index(4) new_rule_id(29)
  //   new_rule_mask(29) new_rule_type(2) enable_bit(1) accept_bit(1) pad(7)
  input  wire logic [cirf_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: mode(3)
  input  wire logic [cirf_pkg::ModeW-1:0]    s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata, low bit up: accepted(1) status(2) slot(4) rules_in_use(5)
  //   read_id(29) read_mask(29) read_type(2) read_enabled(1) read_accept(1)
  //   pad(6)
  output logic [cirf_pkg::OutDataW-1:0]      m_axis_tdata,
  // Configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int AW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int CW  = $clog2(NUM_RULES + 1);
  localparam int IdW = (ID_BITS < cirf_pkg::IdFieldW) ? ID_BITS : cirf_pkg::IdFieldW;
  localparam int XW  = ((CW > cirf_pkg::IndexW) ? CW : cirf_pkg::IndexW) + 1;
  localparam int IdF = cirf_pkg::IdFieldW;

  typedef struct packed {
    logic [IdW-1:0]             id;
    logic [IdW-1:0]             mask;
    logic [cirf_pkg::TypeW-1:0] rtype;
    logic                       en;
    logic                       acc;
  } rule_t;

  typedef struct packed {
    logic                         accepted;
    cirf_pkg::status_e            status;
    logic [cirf_pkg::SlotW-1:0]   slot;
    logic [IdF-1:0]               rid;
    logic [IdF-1:0]               rmask;
    logic [cirf_pkg::TypeW-1:0]   rtype;
    logic                         ren;
    logic                         racc;
  } res_t;

  // Unpack input payload
  logic [IdF-1:0]                 in_msg_id;
  logic [cirf_pkg::TypeW-1:0]     in_msg_type;
  logic [cirf_pkg::IndexW-1:0]    in_index;
  logic [IdF-1:0]                 in_new_id;
  logic [IdF-1:0]                 in_new_mask;
  logic [cirf_pkg::TypeW-1:0]     in_new_type;
  logic                           in_enable;
  logic                           in_accept;

  assign in_msg_id   = s_axis_tdata[28:0];
  assign in_msg_type = s_axis_tdata[30:29];
  assign in_index    = s_axis_tdata[34:31];
  assign in_new_id   = s_axis_tdata[63:35];
  assign in_new_mask = s_axis_tdata[92:64];
  assign in_new_type = s_axis_tdata[94:93];
  assign in_enable   = s_axis_tdata[95];
  assign in_accept   = s_axis_tdata[96];

  // Control and work registers
  cirf_pkg::state_e               state_q, state_d;
  logic [CW-1:0]                  total_q, total_d;
  logic                           filter_on_q;
  logic                           m_valid_q;
  res_t                           m_res_q;
  logic [cirf_pkg::CountW-1:0]    m_count_q;
  res_t                           res_q, res_d;
  logic [CW-1:0]                  ptr_q, ptr_d;
  logic                           any_q, any_d;
  logic [IdW-1:0]                 msg_id_q, msg_id_d;
  logic [cirf_pkg::TypeW-1:0]     msg_type_q, msg_type_d;
  logic                           en_bit_q, en_bit_d;
  logic                           out_load;

  // Rule RAM ports
  rule_t                          rule_mem_q [NUM_RULES];
  rule_t                          rd_q;
  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_waddr, mem_raddr;
  rule_t                          mem_wdata;

  // Index arithmetic
  logic [XW-1:0]                  idx_x, total_x, ptr_x;
  logic                           idx_ok;
  cirf_pkg::eval_t                ev;

  assign idx_x   = XW'(in_index);
  assign total_x = XW'(total_q);
  assign ptr_x   = XW'(ptr_q);
  assign idx_ok  = idx_x < total_x;

  cirf_rule_eval #(
    .IdW (IdW)
  ) u_eval (
    .rule_id_i    (rd_q.id),
    .rule_mask_i  (rd_q.mask),
    .rule_type_i  (rd_q.rtype),
    .rule_en_i    (rd_q.en),
    .rule_acc_i   (rd_q.acc),
    .frame_id_i   (msg_id_q),
    .frame_type_i (msg_type_q),
    .eval_o       (ev)
  );

  assign s_axis_tready = (state_q == cirf_pkg::ST_IDLE);

  // Sequencer: next state, RAM strobes and result assembly
  always_comb begin
    logic [XW-1:0] nxt;
    state_d    = state_q;
    total_d    = total_q;
    res_d      = res_q;
    ptr_d      = ptr_q;
    any_d      = any_q;
    msg_id_d   = msg_id_q;
    msg_type_d = msg_type_q;
    en_bit_d   = en_bit_q;
    mem_we     = 1'b0;
    mem_waddr  = ptr_q[AW-1:0];
    mem_wdata  = rd_q;
    mem_re     = 1'b0;
    mem_raddr  = ptr_q[AW-1:0];
    out_load   = 1'b0;
    nxt        = '0;

    unique case (state_q)
      cirf_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_d      = '0;
          msg_id_d   = in_msg_id[IdW-1:0];
          msg_type_d = in_msg_type;
          en_bit_d   = in_enable;
          ptr_d      = CW'(idx_x);
          state_d    = cirf_pkg::ST_DONE;
          unique case (cirf_pkg::mode_e'(s_axis_tuser))
            cirf_pkg::MODE_CHECK: begin
              if (!filter_on_q || (total_q == '0)) begin
                res_d.accepted = 1'b1;
              end else begin
                // start the walk at rule zero
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_d     = '0;
                any_d     = 1'b0;
                state_d   = cirf_pkg::ST_CHECK;
              end
            end
            cirf_pkg::MODE_ADD: begin
              if (total_x == XW'(NUM_RULES)) begin
                res_d.status = cirf_pkg::STAT_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = total_q[AW-1:0];
                mem_wdata.id    = in_new_id[IdW-1:0];
                mem_wdata.mask  = in_new_mask[IdW-1:0];
                mem_wdata.rtype = in_new_type;
                mem_wdata.en    = in_enable;
                mem_wdata.acc   = in_accept;
                res_d.slot      = total_x[cirf_pkg::SlotW-1:0];
                total_d         = CW'(total_x + XW'(1));
              end
            end
            cirf_pkg::MODE_REMOVE: begin
              nxt = idx_x + XW'(1);
              if (!idx_ok) begin
                res_d.status = cirf_pkg::STAT_RANGE;
              end else if (nxt == total_x) begin
                // last rule: nothing to shift
                total_d = CW'(total_x - XW'(1));
              end else begin
                mem_re    = 1'b1;
                mem_raddr = nxt[AW-1:0];
                state_d   = cirf_pkg::ST_REMOVE;
              end
            end
            cirf_pkg::MODE_SET_EN: begin
              if (!idx_ok) begin
                res_d.status = cirf_pkg::STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_x[AW-1:0];
                state_d   = cirf_pkg::ST_SET_EN;
              end
            end
            cirf_pkg::MODE_CLEAR: begin
              total_d = '0;
            end
            cirf_pkg::MODE_READ: begin
              if (!idx_ok) begin
                res_d.status = cirf_pkg::STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_x[AW-1:0];
                state_d   = cirf_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      cirf_pkg::ST_CHECK: begin
        // rd_q holds rule ptr_q
        nxt   = ptr_x + XW'(1);
        any_d = any_q | ev.acc_rule;
        if (ev.hit) begin
          res_d.accepted = ev.decision;
          state_d        = cirf_pkg::ST_DONE;
        end else if (nxt == total_x) begin
          res_d.accepted = !(any_q | ev.acc_rule);
          state_d        = cirf_pkg::ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = nxt[AW-1:0];
          ptr_d     = CW'(nxt);
        end
      end

      cirf_pkg::ST_REMOVE: begin
        // rd_q holds rule ptr_q + 1; move it down one slot
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AW-1:0];
        mem_wdata = rd_q;
        nxt       = ptr_x + XW'(2);
        if (nxt == total_x) begin
          total_d = CW'(total_x - XW'(1));
          state_d = cirf_pkg::ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = nxt[AW-1:0];
          ptr_d     = CW'(ptr_x + XW'(1));
        end
      end

      cirf_pkg::ST_SET_EN: begin
        mem_we       = 1'b1;
        mem_waddr    = ptr_q[AW-1:0];
        mem_wdata    = rd_q;
        mem_wdata.en = en_bit_q;
        state_d      = cirf_pkg::ST_DONE;
      end

      cirf_pkg::ST_READ: begin
        res_d.rid   = IdF'(rd_q.id);
        res_d.rmask = IdF'(rd_q.mask);
        res_d.rtype = rd_q.rtype;
        res_d.ren   = rd_q.en;
        res_d.racc  = rd_q.acc;
        state_d     = cirf_pkg::ST_DONE;
      end

      cirf_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = cirf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cirf_pkg::ST_IDLE;
      end
    endcase
  end

  // Rule RAM: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rule_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= rule_mem_q[mem_raddr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cirf_pkg::ST_IDLE;
      total_q     <= '0;
      filter_on_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (psel && penable && pwrite && (paddr[2] == cirf_pkg::RegFilterOn)) begin
        filter_on_q <= pwdata[0];
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Work and output payload
  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    ptr_q      <= ptr_d;
    any_q      <= any_d;
    msg_id_q   <= msg_id_d;
    msg_type_q <= msg_type_d;
    en_bit_q   <= en_bit_d;
    if (out_load) begin
      m_res_q   <= res_q;
      m_count_q <= cirf_pkg::CountW'(total_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {
    6'b0,
    m_res_q.racc,
    m_res_q.ren,
    m_res_q.rtype,
    m_res_q.rmask,
    m_res_q.rid,
    m_count_q,
    m_res_q.slot,
    m_res_q.status,
    m_res_q.accepted
  };

  // APB read and ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cirf_pkg::RegFilterOn) ? {31'b0, filter_on_q} : 32'b0;

  // Assertions
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_x <= XW'(NUM_RULES))
    else $error("rule count beyond table depth");

  a_walk_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cirf_pkg::ST_CHECK) |-> (ptr_x < total_x))
    else $error("check walk past last rule");

  a_shift_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cirf_pkg::ST_REMOVE) |-> ((ptr_x + XW'(1)) < total_x))
    else $error("remove shift reads past last rule");

endmodule

`default_nettype wire

// ===== src/cirf_rule_eval.sv =====
// ----------------------------------------------------------------------------
// CAN id rule evaluator
// Compares one rule read from the table with the frame under test.
// ----------------------------------------------------------------------------
`default_nettype none

module cirf_rule_eval #(
  parameter int IdW = cirf_pkg::IdBitsDef
) (
  input  wire logic [IdW-1:0]             rule_id_i,
  input  wire logic [IdW-1:0]             rule_mask_i,
  input  wire logic [cirf_pkg::TypeW-1:0] rule_type_i,
  input  wire logic                       rule_en_i,
  input  wire logic                       rule_acc_i,
  input  wire logic [IdW-1:0]             frame_id_i,
  input  wire logic [cirf_pkg::TypeW-1:0] frame_type_i,
  output cirf_pkg::eval_t                 eval_o
);

  logic id_match;

  assign id_match = ((frame_id_i ^ rule_id_i) & rule_mask_i) == '0;

  always_comb begin
    eval_o.hit      = rule_en_i && (rule_type_i == frame_type_i) && id_match;
    eval_o.acc_rule = rule_en_i && rule_acc_i;
    eval_o.decision = rule_acc_i;
  end

endmodule

`default_nettype wire
